@@ design/bilinear_image_resizer_assert.svh @@
// Assertion macros used by the checker of the resizer.
`ifndef BILINEAR_IMAGE_RESIZER_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZER_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define BIR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs across reset.
`define BIR_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bir_pkg.sv @@
// Shared constants, types and register codes of the bilinear resizer.
`default_nettype none
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 16;

  localparam int XW     = $clog2(MAX_SRC_WIDTH);
  localparam int YW     = $clog2(MAX_SRC_HEIGHT);
  localparam int CW     = (XW > YW) ? XW : YW;
  localparam int ADDR_W = XW + YW;
  localparam int PW     = 12;
  localparam int CH_W   = 8;
  localparam int NCH    = 4;
  localparam int WORD_W = NCH * CH_W;
  localparam int QW     = CW + FRAC_BITS;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int TERM_W = CH_W + FRAC_BITS + 1;
  localparam int ACC_W  = CH_W + 2 * FRAC_BITS + 1;

  localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << FRAC_BITS;

  // register indexes
  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_DST_W = 3'd2;
  localparam logic [2:0] REG_DST_H = 3'd3;
  localparam logic [2:0] REG_NCH   = 3'd4;

  // neighbor read order
  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_10 = 2'd1;
  localparam logic [1:0] NB_01 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  typedef struct packed {
    logic              is_rsz;
    logic              st_ok;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [PW-1:0]     px;
    logic [PW-1:0]     py;
    logic [PW-1:0]     dx;
    logic [PW-1:0]     dy;
    logic [CW-1:0]     smx;
    logic [CW-1:0]     smy;
    logic [2:0]        nch;
  } in_t;

  typedef struct packed {
    logic              is_rsz;
    logic              st_ok;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [PW-1:0]     rx;
    logic [PW-1:0]     ry;
    logic [QW-1:0]     sx;
    logic [QW-1:0]     sy;
    logic [PW-1:0]     dx;
    logic [PW-1:0]     dy;
    logic [CW-1:0]     smx;
    logic [CW-1:0]     smy;
    logic [2:0]        nch;
  } div_t;

  typedef struct packed {
    logic [1:0]           k;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [2:0]           nch;
  } tag_t;

endpackage
`default_nettype wire

@@ design/bilinear_image_resizer.sv @@
// Top level of the bilinear image resizer with frame store.
`default_nettype none
// Bilinear resizer, corner-aligned. Issue a transaction with start while
// busy is low. Store transactions (req_type_i = 0) write one pixel into the
// 256x256 frame store and give no result; stores outside it are dropped.
// Resize transactions (req_type_i = 1) give exactly one pixel on out_c*_o,
// marked by a one-cycle out_strobe_o that cannot be held off; the strobe
// is delayed while the pipeline holds behind an earlier resize. Results
// come out in issue order. A resize holds the single frame-store port for
// its four neighbor reads, a store for its one write, so a new transaction
// can follow a store at once but must wait out a resize; busy is high while
// a resize issues its three remaining reads, and the whole mapping pipeline
// holds then. Coordinates are mapped by one multiply stage and a 24-stage
// divider pipeline, one quotient bit per stage. Stores and resizes share
// that pipeline, so a resize always sees every store issued before it.
// Configuration writes are always accepted (cfg_ready high); change them
// only while no resize is in flight.
module bilinear_image_resizer import bir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [7:0]  in_c0_i,
  input  logic [7:0]  in_c1_i,
  input  logic [7:0]  in_c2_i,
  input  logic [7:0]  in_c3_i,
  output logic        out_strobe_o,
  output logic [7:0]  out_c0_o,
  output logic [7:0]  out_c1_o,
  output logic [7:0]  out_c2_o,
  output logic [7:0]  out_c3_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  // configuration registers, raw as written
  logic [8:0]  src_w_q, src_h_q;
  logic [11:0] dst_w_q, dst_h_q;
  logic [2:0]  nch_q;

  // input stage
  logic accept, adv;
  logic in_vld_q;
  in_t  in_q, in_d;
  logic [8:0] sw, sh;

  // memory sequencer
  logic                 tv, take;
  div_t                 tail;
  logic                 act_q;
  logic [1:0]           ph_q;
  logic [CW-1:0]        x0, x1, y0, y1;
  logic [CW-1:0]        cx0_q, cx1_q, cy0_q, cy1_q;
  logic [FRAC_BITS-1:0] cfx_q, cfy_q;
  logic [2:0]           cnch_q;
  logic                 mem_we, rd_valid;
  logic [ADDR_W-1:0]    mem_addr;
  tag_t                 tag;
  logic [WORD_W-1:0]    rdata;
  logic [NCH-1:0][CH_W-1:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 12'd256;
      dst_h_q <= 12'd256;
      nch_q   <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        REG_SRC_W: src_w_q <= cfg_data_i[8:0];
        REG_SRC_H: src_h_q <= cfg_data_i[8:0];
        REG_DST_W: dst_w_q <= cfg_data_i;
        REG_DST_H: dst_h_q <= cfg_data_i;
        REG_NCH:   nch_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // the pipeline only moves while the memory port is free for a new transaction
  assign adv    = !act_q;
  assign busy   = act_q;
  assign accept = start && !busy;

  always_comb begin
    // clamp source sizes to 1..max
    if (src_w_q == 9'd0) begin
      sw = 9'd1;
    end else if (src_w_q > MAX_SRC_WIDTH) begin
      sw = 9'(MAX_SRC_WIDTH);
    end else begin
      sw = src_w_q;
    end
    if (src_h_q == 9'd0) begin
      sh = 9'd1;
    end else if (src_h_q > MAX_SRC_HEIGHT) begin
      sh = 9'(MAX_SRC_HEIGHT);
    end else begin
      sh = src_h_q;
    end

    in_d.is_rsz = req_type_i;
    in_d.st_ok  = (pos_x_i < MAX_SRC_WIDTH) && (pos_y_i < MAX_SRC_HEIGHT);
    in_d.addr   = {pos_y_i[YW-1:0], pos_x_i[XW-1:0]};
    in_d.data   = {in_c3_i, in_c2_i, in_c1_i, in_c0_i};
    in_d.smx    = CW'(sw - 9'd1);
    in_d.smy    = CW'(sh - 9'd1);

    // single-pixel destination maps to 0: numerator 0 over divisor 1
    if (dst_w_q <= 12'd1) begin
      in_d.dx = 12'd1;
      in_d.px = 12'd0;
    end else begin
      in_d.dx = dst_w_q - 12'd1;
      in_d.px = (pos_x_i > in_d.dx) ? in_d.dx : pos_x_i;
    end
    if (dst_h_q <= 12'd1) begin
      in_d.dy = 12'd1;
      in_d.py = 12'd0;
    end else begin
      in_d.dy = dst_h_q - 12'd1;
      in_d.py = (pos_y_i > in_d.dy) ? in_d.dy : pos_y_i;
    end

    if (nch_q == 3'd0) begin
      in_d.nch = 3'd1;
    end else if (nch_q > 3'(NCH)) begin
      in_d.nch = 3'(NCH);
    end else begin
      in_d.nch = nch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
  end

  bir_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_vld_q),
    .in_i        (in_q),
    .out_valid_o (tv),
    .out_o       (tail)
  );

  // integer and right/bottom neighbor of the mapped position
  assign take = adv && tv;
  assign x0   = tail.sx[QW-1:FRAC_BITS];
  assign y0   = tail.sy[QW-1:FRAC_BITS];
  assign x1   = (x0 < tail.smx) ? x0 + CW'(1) : x0;
  assign y1   = (y0 < tail.smy) ? y0 + CW'(1) : y0;

  // sequencer: the take cycle reads the top-left neighbor, then three more
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ph_q  <= NB_00;
    end else if (take && tail.is_rsz) begin
      act_q <= 1'b1;
      ph_q  <= NB_10;
    end else if (act_q) begin
      ph_q <= ph_q + 2'd1;
      if (ph_q == NB_11) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && tail.is_rsz) begin
      cx0_q  <= x0;
      cx1_q  <= x1;
      cy0_q  <= y0;
      cy1_q  <= y1;
      cfx_q  <= tail.sx[FRAC_BITS-1:0];
      cfy_q  <= tail.sy[FRAC_BITS-1:0];
      cnch_q <= tail.nch;
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    rd_valid = 1'b0;
    mem_addr = tail.addr;
    tag.k    = NB_00;
    tag.fx   = cfx_q;
    tag.fy   = cfy_q;
    tag.nch  = cnch_q;
    if (take) begin
      if (tail.is_rsz) begin
        rd_valid = 1'b1;
        mem_addr = {y0[YW-1:0], x0[XW-1:0]};
        tag.fx   = tail.sx[FRAC_BITS-1:0];
        tag.fy   = tail.sy[FRAC_BITS-1:0];
        tag.nch  = tail.nch;
      end else begin
        mem_we = tail.st_ok;
      end
    end else if (act_q) begin
      rd_valid = 1'b1;
      tag.k    = ph_q;
      case (ph_q)
        NB_10:   mem_addr = {cy0_q[YW-1:0], cx1_q[XW-1:0]};
        NB_01:   mem_addr = {cy1_q[YW-1:0], cx0_q[XW-1:0]};
        NB_11:   mem_addr = {cy1_q[YW-1:0], cx1_q[XW-1:0]};
        default: mem_addr = {cy0_q[YW-1:0], cx0_q[XW-1:0]};
      endcase
    end
  end

  bir_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (tail.data),
    .rdata_o (rdata)
  );

  bir_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_valid_i   (rd_valid),
    .tag_i        (tag),
    .rdata_i      (rdata),
    .out_strobe_o (out_strobe_o),
    .out_o        (res)
  );

  assign out_c0_o = res[0];
  assign out_c1_o = res[1];
  assign out_c2_o = res[2];
  assign out_c3_o = res[3];

endmodule
`default_nettype wire

@@ design/bir_ram.sv @@
// Single-port frame store, registered read.
`default_nettype none
module bir_ram import bir_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

@@ design/bir_div.sv @@
// Pipelined coordinate mapper: one multiply stage, then one quotient bit per stage.
`default_nettype none
module bir_div import bir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic in_valid_i,
  input  in_t  in_i,
  output logic out_valid_o,
  output div_t out_o
);

  function automatic div_t div_step(div_t a);
    div_t       b;
    logic [PW:0] tx;
    logic [PW:0] ty;
    b  = a;
    tx = {a.rx, a.sx[QW-1]};
    ty = {a.ry, a.sy[QW-1]};
    if (tx >= {1'b0, a.dx}) begin
      tx   = tx - {1'b0, a.dx};
      b.sx = {a.sx[QW-2:0], 1'b1};
    end else begin
      b.sx = {a.sx[QW-2:0], 1'b0};
    end
    if (ty >= {1'b0, a.dy}) begin
      ty   = ty - {1'b0, a.dy};
      b.sy = {a.sy[QW-2:0], 1'b1};
    end else begin
      b.sy = {a.sy[QW-2:0], 1'b0};
    end
    b.rx = tx[PW-1:0];
    b.ry = ty[PW-1:0];
    return b;
  endfunction

  logic [QW:0]         vld_q;
  div_t                stg_q [QW+1];
  logic [PW+CW-1:0]    prod_x;
  logic [PW+CW-1:0]    prod_y;
  div_t                stg0_d;

  assign prod_x = (PW+CW)'(in_i.px) * (PW+CW)'(in_i.smx);
  assign prod_y = (PW+CW)'(in_i.py) * (PW+CW)'(in_i.smy);

  always_comb begin
    stg0_d.is_rsz = in_i.is_rsz;
    stg0_d.st_ok  = in_i.st_ok;
    stg0_d.addr   = in_i.addr;
    stg0_d.data   = in_i.data;
    stg0_d.rx     = prod_x[PW+CW-1:CW];
    stg0_d.ry     = prod_y[PW+CW-1:CW];
    stg0_d.sx     = {prod_x[CW-1:0], {FRAC_BITS{1'b0}}};
    stg0_d.sy     = {prod_y[CW-1:0], {FRAC_BITS{1'b0}}};
    stg0_d.dx     = in_i.dx;
    stg0_d.dy     = in_i.dy;
    stg0_d.smx    = in_i.smx;
    stg0_d.smy    = in_i.smy;
    stg0_d.nch    = in_i.nch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[QW-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stg_q[0] <= stg0_d;
      for (int i = 1; i <= QW; i++) begin
        stg_q[i] <= div_step(stg_q[i-1]);
      end
    end
  end

  assign out_valid_o = vld_q[QW];
  assign out_o       = stg_q[QW];

endmodule
`default_nettype wire

@@ design/bir_blend.sv @@
// Blend datapath: x-weight term, y-weighted accumulate, round and saturate, zero unused channels.
`default_nettype none
module bir_blend import bir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_valid_i,
  input  tag_t                       tag_i,
  input  logic [WORD_W-1:0]          rdata_i,
  output logic                       out_strobe_o,
  output logic [NCH-1:0][CH_W-1:0]   out_o
);

  localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1) << (2 * FRAC_BITS - 1);

  logic                     v1_q, v2_q, done_q;
  tag_t                     tag1_q;
  logic [TERM_W-1:0]        term_q [NCH];
  logic [WT_W-1:0]          wy_q;
  logic                     first_q, last_q;
  logic [2:0]               nch2_q, nch3_q;
  logic [ACC_W-1:0]         acc_q [NCH];
  logic [WT_W-1:0]          wx;
  logic [WT_W-1:0]          wy;
  logic [ACC_W:0]           rnd [NCH];
  logic [CH_W:0]            rsh [NCH];

  assign wx = tag1_q.k[0] ? WT_W'(tag1_q.fx) : WT_ONE - WT_W'(tag1_q.fx);
  assign wy = tag1_q.k[1] ? WT_W'(tag1_q.fy) : WT_ONE - WT_W'(tag1_q.fy);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rnd[c] = {1'b0, acc_q[c]} + HALF;
      rsh[c] = rnd[c][2*FRAC_BITS +: CH_W+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      done_q       <= 1'b0;
      out_strobe_o <= 1'b0;
    end else begin
      v1_q         <= rd_valid_i;
      v2_q         <= v1_q;
      done_q       <= v2_q && last_q;
      out_strobe_o <= done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= tag_i;
    if (v1_q) begin
      for (int c = 0; c < NCH; c++) begin
        term_q[c] <= TERM_W'(rdata_i[c*CH_W +: CH_W]) * TERM_W'(wx);
      end
      wy_q    <= wy;
      first_q <= (tag1_q.k == NB_00);
      last_q  <= (tag1_q.k == NB_11);
      nch2_q  <= tag1_q.nch;
    end
    if (v2_q) begin
      for (int c = 0; c < NCH; c++) begin
        acc_q[c] <= (first_q ? '0 : acc_q[c]) + ACC_W'(ACC_W'(term_q[c]) * ACC_W'(wy_q));
      end
      if (last_q) begin
        nch3_q <= nch2_q;
      end
    end
    if (done_q) begin
      for (int c = 0; c < NCH; c++) begin
        if (3'(c) < nch3_q) begin
          out_o[c] <= (rsh[c] > (CH_W+1)'(255)) ? {CH_W{1'b1}} : rsh[c][CH_W-1:0];
        end else begin
          out_o[c] <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/bir_checker.sv @@
// Port-level checks of the resizer and their bind to the top level.
`default_nettype none
`include "bilinear_image_resizer_assert.svh"
module bir_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic out_strobe_o
);

  // a resize owns the frame-store port for its four neighbor reads, so strobes are spaced
  `BIR_ASSERT_RST(a_strobe_gap1, clk_i, rst_ni, out_strobe_o |=> !out_strobe_o, "strobe gap 1")
  `BIR_ASSERT_RST(a_strobe_gap2, clk_i, rst_ni, out_strobe_o |-> ##2 !out_strobe_o, "strobe gap 2")
  `BIR_ASSERT_RST(a_strobe_gap3, clk_i, rst_ni, out_strobe_o |-> ##3 !out_strobe_o, "strobe gap 3")
  // nothing is owed right after reset
  `BIR_ASSERT(a_idle_after_reset, clk_i, $rose(rst_ni) |-> !busy, "busy after reset")

endmodule

bind bilinear_image_resizer bir_checker u_bir_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .out_strobe_o (out_strobe_o)
);
`default_nettype wire
